@@ rtl/psw_pkg.sv @@
// Shared types and constants for the priority schedule wait-time block.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package psw_pkg;

   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);
   localparam int BURST_W   = 16;
   localparam int PRIO_W    = 8;
   localparam int ID_W      = 5;
   localparam int TIME_W    = 20;
   localparam int TOT_W     = 25;
   localparam int STEP_W    = $clog2(TOT_W);

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
   } psw_entry_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic [CNT_W-1:0]  count;
      psw_entry_type     entry;
   } psw_beat_type;

endpackage

@@ rtl/psw_div.sv @@
// Restoring divider, one quotient bit per cycle, for the schedule averages.
// Depends on psw_pkg.
`timescale 1ns / 1ps

module psw_div
   import psw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [TOT_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [TOT_W-1:0] quotient
);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [TOT_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  div_ff;
   logic [CNT_W:0]    rem_shift;
   logic              ge;
   logic [CNT_W-1:0]  rem_in;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[TOT_W-1]};
      ge        = (rem_shift >= {1'b0, div_ff});
      rem_in    = ge ? CNT_W'(rem_shift - {1'b0, div_ff}) : CNT_W'(rem_shift);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
         step_ff <= STEP_W'(TOT_W - 1);
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quo_ff  <= {quo_ff[TOT_W-2:0], ge};
         step_ff <= step_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/psw_sorter.sv @@
// Process store with load, in-place exchange sort and ordered read-out.
// Holds the entry memory; depends on psw_pkg.
`timescale 1ns / 1ps

module psw_sorter
   import psw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [BURST_W-1:0] burst_time,
   input  logic [PRIO_W-1:0]  prio_value,
   input  logic               last_process,
   output logic               loading,
   output psw_beat_type       beat
);

   localparam logic [2:0] ST_LOAD = 3'd0;
   localparam logic [2:0] ST_RDI  = 3'd1;
   localparam logic [2:0] ST_LDI  = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_WRI  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;
   localparam logic [2:0] ST_TAIL = 3'd6;

   psw_entry_type     mem [MAX_PROCS];

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   psw_entry_type     a_ff, a_in;
   psw_entry_type     rd_ff;
   logic              rv_ff, rv_in;
   logic              rl_ff, rl_in;

   logic              we;
   logic [IDX_W-1:0]  waddr;
   psw_entry_type     wdata;
   logic [CNT_W-1:0]  raddr;
   logic [CNT_W-1:0]  cnt_next;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      a_in     = a_ff;
      rv_in    = 1'b0;
      rl_in    = 1'b0;
      we       = 1'b0;
      waddr    = i_ff[IDX_W-1:0];
      wdata    = a_ff;
      raddr    = i_ff;
      cnt_next = (cnt_ff < CNT_W'(MAX_PROCS)) ? cnt_ff + 1'b1 : cnt_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (cnt_ff < CNT_W'(MAX_PROCS)) begin
                  we          = 1'b1;
                  waddr       = cnt_ff[IDX_W-1:0];
                  wdata.id    = ID_W'(cnt_ff) + ID_W'(1);
                  wdata.prio  = prio_value;
                  wdata.burst = burst_time;
               end
               cnt_in = cnt_next;
               if (last_process) begin
                  i_in     = '0;
                  k_in     = '0;
                  state_in = (cnt_next > CNT_W'(1)) ? ST_RDI : ST_EMIT;
               end
            end
         end
         ST_RDI: begin
            raddr    = i_ff;
            j_in     = i_ff + 1'b1;
            state_in = ST_LDI;
         end
         ST_LDI: begin
            a_in     = rd_ff;
            raddr    = j_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            raddr = j_ff + 1'b1;
            if (a_ff.prio < rd_ff.prio) begin
               we    = 1'b1;
               waddr = j_ff[IDX_W-1:0];
               wdata = a_ff;
               a_in  = rd_ff;
            end
            if (j_ff + 1'b1 < cnt_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = ST_WRI;
            end
         end
         ST_WRI: begin
            we    = 1'b1;
            waddr = i_ff[IDX_W-1:0];
            wdata = a_ff;
            i_in  = i_ff + 1'b1;
            if (i_ff + 1'b1 >= cnt_ff - 1'b1) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_RDI;
            end
         end
         ST_EMIT: begin
            raddr = k_ff;
            k_in  = k_ff + 1'b1;
            rv_in = 1'b1;
            if (k_ff + 1'b1 == cnt_ff) begin
               rl_in    = 1'b1;
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            cnt_in   = '0;
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
         rl_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
         rl_ff    <= rl_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      a_ff <= a_in;
   end

   assign loading     = (state_ff == ST_LOAD);
   assign beat.valid  = rv_ff;
   assign beat.last   = rl_ff;
   assign beat.count  = cnt_ff;
   assign beat.entry  = rd_ff;

endmodule

@@ rtl/priority_schedule_wait_times.sv @@
// Results: after the beat with last_process the set is sorted; non-final results come
// one per cycle; the last, with both averages, follows once both dividers are done.
// Throughput: one load beat per cycle while busy is low; the entry-memory sort and the
// 25-step average dividers set the time per set; busy drops in the cycle of the last result.
// Reset: synchronous, clears control and totals; the entry memory is not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps

module priority_schedule_wait_times
   import psw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [BURST_W-1:0] req_burst_time,
   input  logic [PRIO_W-1:0]  req_prio_value,
   input  logic               req_last_process,
   output logic               rsp_strobe,
   output logic [ID_W-1:0]    rsp_process_id,
   output logic [BURST_W-1:0] rsp_burst_out,
   output logic [PRIO_W-1:0]  rsp_prio_out,
   output logic [TIME_W-1:0]  rsp_wait_time,
   output logic [TIME_W-1:0]  rsp_turnaround_time,
   output logic [TIME_W-1:0]  rsp_avg_wait,
   output logic [TIME_W-1:0]  rsp_avg_turnaround,
   output logic               rsp_last_result
);

   psw_beat_type      beat;
   logic              loading;
   logic              accept;

   logic              hold_ff;
   logic [TIME_W-1:0] run_ff, run_in;
   logic [TOT_W-1:0]  wtot_ff, wtot_in;
   logic [TOT_W-1:0]  ttot_ff, ttot_in;
   logic [TIME_W:0]   tat_sum;
   logic [TIME_W-1:0] tat;
   logic [TOT_W:0]    wsum;
   logic [TOT_W:0]    tsum;

   logic              div_start;
   logic              wdone, tdone;
   logic [TOT_W-1:0]  wquo, tquo;

   logic              strobe_ff;
   logic [ID_W-1:0]   id_ff;
   logic [BURST_W-1:0] burst_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic [TIME_W-1:0] wait_ff;
   logic [TIME_W-1:0] tat_ff;
   logic [TIME_W-1:0] avgw_ff;
   logic [TIME_W-1:0] avgt_ff;
   logic              last_ff;

   assign busy   = ~loading | hold_ff;
   assign accept = start & ~busy;

   psw_sorter u_sorter (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .burst_time   (req_burst_time),
      .prio_value   (req_prio_value),
      .last_process (req_last_process),
      .loading      (loading),
      .beat         (beat)
   );

   always_comb begin
      tat_sum = {1'b0, run_ff} + (TIME_W + 1)'(beat.entry.burst);
      tat     = tat_sum[TIME_W] ? TIME_MAX : tat_sum[TIME_W-1:0];
      wsum    = {1'b0, wtot_ff} + (TOT_W + 1)'(run_ff);
      tsum    = {1'b0, ttot_ff} + (TOT_W + 1)'(tat);
      wtot_in = wsum[TOT_W] ? '1 : wsum[TOT_W-1:0];
      ttot_in = tsum[TOT_W] ? '1 : tsum[TOT_W-1:0];
      run_in  = tat;
      div_start = beat.valid & beat.last;
   end

   psw_div u_div_wait (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wtot_in),
      .divisor  (beat.count),
      .done     (wdone),
      .quotient (wquo)
   );

   psw_div u_div_tat (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ttot_in),
      .divisor  (beat.count),
      .done     (tdone),
      .quotient (tquo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         run_ff    <= '0;
         wtot_ff   <= '0;
         ttot_ff   <= '0;
      end else begin
         strobe_ff <= 1'b0;
         if (beat.valid) begin
            if (beat.last) begin
               hold_ff <= 1'b1;
               run_ff  <= '0;
               wtot_ff <= '0;
               ttot_ff <= '0;
            end else begin
               strobe_ff <= 1'b1;
               run_ff    <= run_in;
               wtot_ff   <= wtot_in;
               ttot_ff   <= ttot_in;
            end
         end else if (hold_ff && wdone && tdone) begin
            hold_ff   <= 1'b0;
            strobe_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (beat.valid) begin
         id_ff    <= beat.entry.id;
         burst_ff <= beat.entry.burst;
         prio_ff  <= beat.entry.prio;
         wait_ff  <= run_ff;
         tat_ff   <= tat;
         avgw_ff  <= '0;
         avgt_ff  <= '0;
         last_ff  <= 1'b0;
      end else if (hold_ff && wdone && tdone) begin
         avgw_ff  <= (wquo > TOT_W'(TIME_MAX)) ? TIME_MAX : wquo[TIME_W-1:0];
         avgt_ff  <= (tquo > TOT_W'(TIME_MAX)) ? TIME_MAX : tquo[TIME_W-1:0];
         last_ff  <= 1'b1;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_process_id      = id_ff;
   assign rsp_burst_out       = burst_ff;
   assign rsp_prio_out        = prio_ff;
   assign rsp_wait_time       = wait_ff;
   assign rsp_turnaround_time = tat_ff;
   assign rsp_avg_wait        = avgw_ff;
   assign rsp_avg_turnaround  = avgt_ff;
   assign rsp_last_result     = last_ff;

endmodule
